// ===== rtl/core/tavs_pkg.sv =====
package tavs_pkg;

	localparam int DIM    = 8;
	localparam int IW     = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int CW     = $clog2(DIM + 1);
	localparam int GDEPTH = DIM * DIM;
	localparam int GA_W   = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
	localparam int VA_W   = IW + 2;
	localparam int VDEPTH = 4 << IW;

	localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	// Regions of the vector memory.
	localparam logic [1:0] RG_RHS  = 2'd0;
	localparam logic [1:0] RG_DIAG = 2'd1;
	localparam logic [1:0] RG_W    = 2'd2;
	localparam logic [1:0] RG_Z    = 2'd3;

	// Configuration register indexes.
	localparam logic [7:0] CFG_REG_WEIGHT = 8'd0;
	localparam logic [7:0] CFG_SCALE_DEG  = 8'd1;
	localparam logic [7:0] CFG_MIN_RATING = 8'd2;
	localparam logic [7:0] CFG_MAX_RATING = 8'd3;

	typedef struct packed {
		logic               done;
		logic               dz;
		logic signed [63:0] value;
	} arith_res_t;

	function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > 65'sd9223372036854775807) return SMAX;
		if (s < -65'sd9223372036854775807) return -SMAX;
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] signed_of(logic [63:0] m, logic neg);
		logic [63:0] c;
		c = (m > 64'(SMAX)) ? 64'(SMAX) : m;
		return neg ? -$signed(c) : $signed(c);
	endfunction

	function automatic logic [GA_W-1:0] gaddr(logic [CW-1:0] r, logic [CW-1:0] c);
		return GA_W'(int'(r) * DIM + int'(c));
	endfunction

	function automatic logic [VA_W-1:0] vaddr(logic [1:0] rg, logic [CW-1:0] ix);
		return {rg, ix[IW-1:0]};
	endfunction

endpackage

// ===== rtl/core/tavs_ifs.sv =====
interface tavs_item_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] own_factor;
	logic signed [31:0] nbr_factor;
	logic signed [31:0] time_factor;
	logic signed [31:0] rating;
	logic               end_of_edge;
	logic               end_of_vertex;
	logic               is_user;

	modport source (output valid, own_factor, nbr_factor, time_factor, rating,
		end_of_edge, end_of_vertex, is_user, input ready);
	modport sink (input valid, own_factor, nbr_factor, time_factor, rating,
		end_of_edge, end_of_vertex, is_user, output ready);
endinterface

interface tavs_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_factor;
	logic [4:0]         factor_index;
	logic [62:0]        error_sum;
	logic               singular;
	logic               last;

	modport source (output valid, new_factor, factor_index, error_sum, singular, last,
		input ready);
	modport sink (input valid, new_factor, factor_index, error_sum, singular, last,
		output ready);
endinterface

interface tavs_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tensor_als_vertex_solve.sv =====
// Tensor ALS vertex solver.
// The item channel takes one factor element per beat: the first DIM elements
// of an edge are kept, an edge is closed by end_of_edge or end_of_vertex, and
// the last edge of a vertex carries end_of_vertex. Each edge end updates the
// upper triangle of the Gram memory, a read and a write per entry, and a user
// edge also adds its error term.
// At vertex end the block adds the regularization to the diagonal and runs an
// LDLT solve on a shared iterative multiplier and a one-bit-per-cycle divider.
// DIM result beats then follow on the result channel.
// One vertex is in work at a time: no item is taken while a solve runs or
// results are pending. A stalled receiver holds the current result beat.
// The configuration channel is always ready; the user is to write it between
// vertices, which the block itself does not enforce.
// Reset clears all accumulators and restores the register defaults; the
// Gram and right-hand-side memories read as zero through valid bits.
module tensor_als_vertex_solve (
	input logic         clk,
	input logic         arst_n,
	tavs_cfg_if.sink    cfg,
	tavs_item_if.sink   item,
	tavs_result_if.source result
);
	import tavs_pkg::*;

	localparam logic [5:0] ST_IDLE = 6'd0, ST_E1 = 6'd1, ST_E2 = 6'd2, ST_E3 = 6'd3,
		ST_E4 = 6'd4, ST_GR_RD = 6'd5, ST_GR_WR = 6'd6, ST_ERR1 = 6'd7, ST_ERR2 = 6'd8,
		ST_ERR3 = 6'd9, ST_FIN = 6'd10, ST_LAM = 6'd11, ST_LAM2 = 6'd12, ST_DG_RD = 6'd13,
		ST_DG_WR = 6'd14, ST_COL = 6'd15, ST_COL_LD = 6'd16, ST_LOOP_CHK = 6'd17,
		ST_ACC_MUL = 6'd18, ST_ACC_WAIT = 6'd19, ST_LOOP_END = 6'd20, ST_ROW_CHK = 6'd21,
		ST_ROW_LD = 6'd22, ST_DIV_WAIT = 6'd23, ST_FWD_CHK = 6'd24, ST_FWD_LD = 6'd25,
		ST_SCL = 6'd26, ST_SCL2 = 6'd27, ST_SCL3 = 6'd28, ST_SCL_WAIT = 6'd29,
		ST_BWD = 6'd30, ST_BWD_LD = 6'd31, ST_OUT = 6'd32, ST_OUT_LD = 6'd33,
		ST_OUT_WAIT = 6'd34;

	localparam logic [1:0] PH_D = 2'd0, PH_S = 2'd1, PH_F = 2'd2, PH_B = 2'd3;

	logic [5:0] state_q;
	logic [1:0] ph_q;
	logic [CW-1:0] i_q, j_q, k_q;
	logic second_q, sing_q, pos_full_q;
	logic [IW-1:0] pos_q;

	logic [30:0] rw_q;
	logic scale_q;
	logic signed [31:0] min_q, max_q;

	logic signed [31:0] own_q, nbr_q, tim_q, rat_q, p_q;
	logic eoe_q, eov_q, usr_q;
	logic signed [63:0] prod_q, pr_q, po_q, gm_q, pred_q, err_q, s_q, d_q, a_q, lam_q;
	logic [63:0] sq_q;
	logic [62:0] lm_q;
	logic [31:0] m_q, ecnt_q;
	logic big_q;

	logic signed [31:0] ep_q [DIM];
	logic [DIM-1:0] epv_q, rv_q;
	logic [GDEPTH-1:0] gv_q;
	logic gmask_q, vmask_q;

	logic signed [31:0] nf_q;
	logic [4:0] fi_q;

	logic g_we, g_re, v_we, v_re;
	logic [GA_W-1:0] g_waddr, g_raddr;
	logic [VA_W-1:0] v_waddr, v_raddr;
	logic signed [63:0] g_wdata, v_wdata, g_rdata, v_rdata, grd_eff, vrd_eff;

	logic mul_start, div_start, loop_go;
	logic signed [63:0] mul_a, mul_b, div_a, div_b;
	arith_res_t mul_res, div_res;
	logic [GA_W-1:0] la;
	logic [VA_W-1:0] lb;

	logic signed [63:0] pr_sh, pc1, pc2, err_v, m_v;

	tavs_ram #(.W(64), .DEPTH(GDEPTH)) u_gram (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.re(g_re), .raddr(g_raddr), .rdata(g_rdata)
	);

	tavs_ram #(.W(64), .DEPTH(VDEPTH)) u_vec (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.re(v_re), .raddr(v_raddr), .rdata(v_rdata)
	);

	tavs_qmul u_qmul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b), .res(mul_res)
	);

	tavs_qdiv u_qdiv (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(div_a), .b(div_b), .res(div_res)
	);

	assign grd_eff = gmask_q ? g_rdata : 64'sd0;
	assign vrd_eff = vmask_q ? v_rdata : 64'sd0;

	assign cfg.ready    = 1'b1;
	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = (state_q == ST_OUT_WAIT);
	assign result.new_factor   = nf_q;
	assign result.factor_index = fi_q;
	assign result.error_sum    = err_q[62:0];
	assign result.singular     = sing_q;
	assign result.last         = (i_q == CW'(DIM - 1));

	// Operand addresses of the inner product loops; the lower triangle of the
	// Gram memory holds the unit lower factor.
	always_comb begin
		case (ph_q)
			PH_D: begin
				la = gaddr(j_q, k_q); lb = vaddr(RG_DIAG, k_q); loop_go = (k_q < j_q);
			end
			PH_S: begin
				la = gaddr(i_q, k_q); lb = vaddr(RG_W, k_q); loop_go = (k_q < j_q);
			end
			PH_F: begin
				la = gaddr(i_q, k_q); lb = vaddr(RG_Z, k_q); loop_go = (k_q < i_q);
			end
			default: begin
				la = gaddr(k_q, i_q); lb = vaddr(RG_Z, k_q); loop_go = (k_q < CW'(DIM));
			end
		endcase
	end

	always_comb begin
		pr_sh = pred_q >>> 16;
		pc1   = (pr_sh > 64'(max_q)) ? 64'(max_q) : pr_sh;
		pc2   = (pc1 < 64'(min_q)) ? 64'(min_q) : pc1;
		err_v = 64'(rat_q) - pc2;
		m_v   = err_v[63] ? -err_v : err_v;
	end

	assign mul_start = (state_q == ST_ACC_MUL) || ((state_q == ST_ACC_WAIT) && mul_res.done
		&& (ph_q == PH_D) && !second_q);
	assign mul_a = (state_q == ST_ACC_MUL) ? g_rdata : a_q;
	assign mul_b = (state_q == ST_ACC_MUL) ? v_rdata : mul_res.value;

	assign div_start = ((state_q == ST_LOOP_END) && (ph_q == PH_S)) || (state_q == ST_SCL3);
	assign div_a = s_q;
	assign div_b = (state_q == ST_SCL3) ? v_rdata : d_q;

	always_comb begin
		g_we = 1'b0; g_re = 1'b0; v_we = 1'b0; v_re = 1'b0;
		g_waddr = '0; g_raddr = '0; v_waddr = '0; v_raddr = '0;
		g_wdata = 64'sd0; v_wdata = 64'sd0;
		case (state_q)
			ST_E2: begin v_re = 1'b1; v_raddr = {RG_RHS, pos_q}; end
			ST_E4: begin
				v_we = 1'b1; v_waddr = {RG_RHS, pos_q}; v_wdata = sadd(vrd_eff, pr_q);
			end
			ST_GR_RD: begin g_re = 1'b1; g_raddr = gaddr(i_q, j_q); end
			ST_GR_WR: begin
				g_we = 1'b1; g_waddr = gaddr(i_q, j_q); g_wdata = sadd(grd_eff, gm_q);
			end
			ST_DG_RD: begin g_re = 1'b1; g_raddr = gaddr(i_q, i_q); end
			ST_DG_WR: begin
				g_we = 1'b1; g_waddr = gaddr(i_q, i_q); g_wdata = sadd(grd_eff, lam_q);
			end
			ST_COL: begin g_re = 1'b1; g_raddr = gaddr(j_q, j_q); end
			ST_LOOP_CHK: begin
				if (loop_go) begin
					g_re = 1'b1; g_raddr = la; v_re = 1'b1; v_raddr = lb;
				end
			end
			ST_ACC_WAIT: begin
				if (mul_res.done && (ph_q == PH_D) && !second_q) begin
					v_we = 1'b1; v_waddr = vaddr(RG_W, k_q); v_wdata = mul_res.value;
				end
			end
			ST_LOOP_END: begin
				if (ph_q == PH_D) begin
					v_we = 1'b1; v_waddr = vaddr(RG_DIAG, j_q); v_wdata = s_q;
				end else if (ph_q != PH_S) begin
					v_we = 1'b1; v_waddr = vaddr(RG_Z, i_q); v_wdata = s_q;
				end
			end
			ST_ROW_CHK: begin
				if (i_q < CW'(DIM)) begin g_re = 1'b1; g_raddr = gaddr(j_q, i_q); end
			end
			ST_DIV_WAIT: begin
				if (div_res.done) begin
					g_we = 1'b1; g_waddr = gaddr(i_q, j_q); g_wdata = div_res.value;
				end
			end
			ST_FWD_CHK: begin
				if (i_q < CW'(DIM)) begin v_re = 1'b1; v_raddr = vaddr(RG_RHS, i_q); end
			end
			ST_SCL: begin
				if (i_q < CW'(DIM)) begin v_re = 1'b1; v_raddr = vaddr(RG_Z, i_q); end
			end
			ST_SCL2: begin v_re = 1'b1; v_raddr = vaddr(RG_DIAG, i_q); end
			ST_SCL_WAIT: begin
				if (div_res.done) begin
					v_we = 1'b1; v_waddr = vaddr(RG_Z, i_q); v_wdata = div_res.value;
				end
			end
			ST_BWD, ST_OUT: begin v_re = 1'b1; v_raddr = vaddr(RG_Z, i_q); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= PH_D;
			i_q <= '0; j_q <= '0; k_q <= '0;
			second_q <= 1'b0; sing_q <= 1'b0;
			pos_q <= '0; pos_full_q <= 1'b0;
			rw_q <= 31'd4260; scale_q <= 1'b0;
			min_q <= 32'sd0; max_q <= 32'sd327680;
			pred_q <= 64'sd0; err_q <= 64'sd0; ecnt_q <= '0;
			epv_q <= '0; rv_q <= '0; gv_q <= '0;
			gmask_q <= 1'b0; vmask_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_REG_WEIGHT: rw_q <= cfg.data[30:0];
					CFG_SCALE_DEG:  scale_q <= cfg.data[0];
					CFG_MIN_RATING: min_q <= $signed(cfg.data);
					CFG_MAX_RATING: max_q <= $signed(cfg.data);
					default: ;
				endcase
			end
			if (g_re) gmask_q <= gv_q[g_raddr];
			if (v_re) vmask_q <= (v_raddr[VA_W-1:IW] == RG_RHS) ? rv_q[v_raddr[IW-1:0]] : 1'b1;
			if (g_we) gv_q[g_waddr] <= 1'b1;

			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						own_q <= item.own_factor; nbr_q <= item.nbr_factor;
						tim_q <= item.time_factor; rat_q <= item.rating;
						eoe_q <= item.end_of_edge; eov_q <= item.end_of_vertex;
						usr_q <= item.is_user;
						if (!pos_full_q) begin
							state_q <= ST_E1;
						end else if (item.end_of_edge || item.end_of_vertex) begin
							i_q <= '0; j_q <= '0; state_q <= ST_GR_RD;
						end
					end
				end
				ST_E1: begin prod_q <= nbr_q * tim_q; state_q <= ST_E2; end
				ST_E2: begin
					p_q <= sat32(prod_q >>> 16);
					ep_q[pos_q] <= sat32(prod_q >>> 16);
					epv_q[pos_q] <= 1'b1;
					state_q <= ST_E3;
				end
				ST_E3: begin
					pr_q <= p_q * rat_q; po_q <= own_q * p_q; state_q <= ST_E4;
				end
				ST_E4: begin
					pred_q <= sadd(pred_q, po_q);
					rv_q[pos_q] <= 1'b1;
					if (32'(pos_q) + 32'd1 >= 32'(DIM)) pos_full_q <= 1'b1;
					else pos_q <= pos_q + IW'(1);
					if (eoe_q || eov_q) begin
						i_q <= '0; j_q <= '0; state_q <= ST_GR_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_GR_RD: begin
					gm_q <= (epv_q[i_q[IW-1:0]] && epv_q[j_q[IW-1:0]])
						? ep_q[i_q[IW-1:0]] * ep_q[j_q[IW-1:0]] : 64'sd0;
					state_q <= ST_GR_WR;
				end
				ST_GR_WR: begin
					if (j_q == CW'(DIM - 1)) begin
						if (i_q == CW'(DIM - 1)) begin
							state_q <= usr_q ? ST_ERR1 : ST_FIN;
						end else begin
							i_q <= i_q + CW'(1); j_q <= i_q + CW'(1); state_q <= ST_GR_RD;
						end
					end else begin
						j_q <= j_q + CW'(1); state_q <= ST_GR_RD;
					end
				end
				ST_ERR1: begin
					big_q <= (m_v > 64'sd3037000499);
					m_q <= m_v[31:0];
					state_q <= ST_ERR2;
				end
				ST_ERR2: begin sq_q <= m_q * m_q; state_q <= ST_ERR3; end
				ST_ERR3: begin
					err_q <= big_q ? SMAX : sadd(err_q, $signed(sq_q));
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (ecnt_q != 32'hFFFF_FFFF) ecnt_q <= ecnt_q + 32'd1;
					pred_q <= 64'sd0; pos_q <= '0; pos_full_q <= 1'b0; epv_q <= '0;
					state_q <= eov_q ? ST_LAM : ST_IDLE;
				end
				ST_LAM: begin lm_q <= rw_q * ecnt_q; state_q <= ST_LAM2; end
				ST_LAM2: begin
					if (!scale_q) lam_q <= $signed({17'd0, rw_q, 16'd0});
					else if (lm_q[62:47] != 16'd0) lam_q <= SMAX;
					else lam_q <= $signed({lm_q[47:0], 16'd0});
					i_q <= '0; sing_q <= 1'b0; state_q <= ST_DG_RD;
				end
				ST_DG_RD: state_q <= ST_DG_WR;
				ST_DG_WR: begin
					if (i_q == CW'(DIM - 1)) begin
						j_q <= '0; state_q <= ST_COL;
					end else begin
						i_q <= i_q + CW'(1); state_q <= ST_DG_RD;
					end
				end
				ST_COL: state_q <= ST_COL_LD;
				ST_COL_LD: begin
					s_q <= grd_eff; k_q <= '0; ph_q <= PH_D; state_q <= ST_LOOP_CHK;
				end
				ST_LOOP_CHK: state_q <= loop_go ? ST_ACC_MUL : ST_LOOP_END;
				ST_ACC_MUL: begin
					a_q <= g_rdata; second_q <= 1'b0; state_q <= ST_ACC_WAIT;
				end
				ST_ACC_WAIT: begin
					if (mul_res.done) begin
						if ((ph_q == PH_D) && !second_q) begin
							second_q <= 1'b1;
						end else begin
							s_q <= sadd(s_q, -mul_res.value);
							k_q <= k_q + CW'(1);
							state_q <= ST_LOOP_CHK;
						end
					end
				end
				ST_LOOP_END: begin
					case (ph_q)
						PH_D: begin d_q <= s_q; i_q <= j_q + CW'(1); state_q <= ST_ROW_CHK; end
						PH_S: state_q <= ST_DIV_WAIT;
						PH_F: begin i_q <= i_q + CW'(1); state_q <= ST_FWD_CHK; end
						default: begin
							if (i_q == '0) state_q <= ST_OUT;
							else begin i_q <= i_q - CW'(1); state_q <= ST_BWD; end
						end
					endcase
				end
				ST_ROW_CHK: begin
					if (i_q < CW'(DIM)) state_q <= ST_ROW_LD;
					else if (j_q == CW'(DIM - 1)) begin i_q <= '0; state_q <= ST_FWD_CHK; end
					else begin j_q <= j_q + CW'(1); state_q <= ST_COL; end
				end
				ST_ROW_LD: begin
					s_q <= grd_eff; k_q <= '0; ph_q <= PH_S; state_q <= ST_LOOP_CHK;
				end
				ST_DIV_WAIT: begin
					if (div_res.done) begin
						sing_q <= sing_q | div_res.dz;
						i_q <= i_q + CW'(1);
						state_q <= ST_ROW_CHK;
					end
				end
				ST_FWD_CHK: begin
					if (i_q < CW'(DIM)) state_q <= ST_FWD_LD;
					else begin i_q <= '0; state_q <= ST_SCL; end
				end
				ST_FWD_LD: begin
					s_q <= vrd_eff; k_q <= '0; ph_q <= PH_F; state_q <= ST_LOOP_CHK;
				end
				ST_SCL: begin
					if (i_q < CW'(DIM)) state_q <= ST_SCL2;
					else begin i_q <= CW'(DIM - 1); state_q <= ST_BWD; end
				end
				ST_SCL2: begin s_q <= v_rdata; state_q <= ST_SCL3; end
				ST_SCL3: state_q <= ST_SCL_WAIT;
				ST_SCL_WAIT: begin
					if (div_res.done) begin
						sing_q <= sing_q | div_res.dz;
						i_q <= i_q + CW'(1);
						state_q <= ST_SCL;
					end
				end
				ST_BWD: state_q <= ST_BWD_LD;
				ST_BWD_LD: begin
					s_q <= v_rdata; k_q <= i_q + CW'(1); ph_q <= PH_B; state_q <= ST_LOOP_CHK;
				end
				ST_OUT: state_q <= ST_OUT_LD;
				ST_OUT_LD: begin
					nf_q <= sat32(v_rdata >>> 16);
					fi_q <= 5'(i_q);
					state_q <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					if (result.ready) begin
						if (i_q == CW'(DIM - 1)) begin
							// The vertex is done: start the next one from empty sums.
							gv_q <= '0; rv_q <= '0; err_q <= 64'sd0; ecnt_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + CW'(1); state_q <= ST_OUT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_in_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !result.valid) else $error("item taken while a result is pending");
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_start && div_start)) else $error("multiplier and divider started together");
	a_gram_rw: assert property (@(posedge clk) disable iff (!arst_n)
		(g_we && g_re) |-> (g_waddr != g_raddr)) else $error("gram read and write collide");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC_MUL) |=> !mul_res.done) else $error("stale multiplier result");
`endif

endmodule

// ===== rtl/core/tavs_ram.sv =====
module tavs_ram #(
	parameter int W = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/tavs_qmul.sv =====
module tavs_qmul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   a,
	input  logic signed [63:0]   b,
	output tavs_pkg::arith_res_t res
);
	import tavs_pkg::*;

	logic [63:0]  ua_q, ub_q, pp_q;
	logic         neg_q, busy_q;
	logic [2:0]   cnt_q;
	logic [1:0]   sh_q;
	logic [127:0] acc_q, pp_ext;

	always_comb begin
		case (sh_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
			default: pp_ext = {pp_q, 64'd0};
		endcase
	end

	// Four 32x32 partial products, one per cycle, summed into a 128-bit word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			ua_q   <= a[63] ? 64'(-a) : 64'(a);
			ub_q   <= b[63] ? 64'(-b) : 64'(b);
			neg_q  <= a[63] ^ b[63];
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q != 3'd0 && cnt_q <= 3'd4) acc_q <= acc_q + pp_ext;
			case (cnt_q)
				3'd0: begin pp_q <= ua_q[31:0] * ub_q[31:0]; sh_q <= 2'd0; end
				3'd1: begin pp_q <= ua_q[31:0] * ub_q[63:32]; sh_q <= 2'd1; end
				3'd2: begin pp_q <= ua_q[63:32] * ub_q[31:0]; sh_q <= 2'd1; end
				3'd3: begin pp_q <= ua_q[63:32] * ub_q[63:32]; sh_q <= 2'd2; end
				default: ;
			endcase
			if (cnt_q == 3'd5) busy_q <= 1'b0;
			else cnt_q <= cnt_q + 3'd1;
		end
	end

	assign res.done  = busy_q && (cnt_q == 3'd5);
	assign res.dz    = 1'b0;
	assign res.value = (acc_q[127:96] != 32'd0) ? signed_of('1, neg_q)
		: signed_of(acc_q[95:32], neg_q);

endmodule

// ===== rtl/core/tavs_qdiv.sv =====
module tavs_qdiv (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   a,
	input  logic signed [63:0]   b,
	output tavs_pkg::arith_res_t res
);
	import tavs_pkg::*;

	logic [63:0] ua, ub_q, r_q, lo_q, q_q;
	logic        neg_q, busy_q, zero_q, ovf_q, fin;
	logic [6:0]  cnt_q;
	logic [64:0] r65;

	assign ua  = a[63] ? 64'(-a) : 64'(a);
	assign fin = zero_q || ovf_q || (cnt_q == 7'd64);
	assign r65 = {r_q, lo_q[63]};

	// Restoring division of (|a| << 32) by |b|, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			ub_q   <= b[63] ? 64'(-b) : 64'(b);
			neg_q  <= a[63] ^ b[63];
			r_q    <= {32'd0, ua[63:32]};
			lo_q   <= {ua[31:0], 32'd0};
			q_q    <= '0;
			zero_q <= (b == 64'sd0);
			ovf_q  <= ({32'd0, ua[63:32]} >= (b[63] ? 64'(-b) : 64'(b)));
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else begin
				if (r65 >= {1'b0, ub_q}) begin
					r_q <= 64'(r65 - {1'b0, ub_q});
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					r_q <= r65[63:0];
					q_q <= {q_q[62:0], 1'b0};
				end
				lo_q  <= {lo_q[62:0], 1'b0};
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	assign res.done  = busy_q && fin;
	assign res.dz    = zero_q;
	assign res.value = zero_q ? 64'sd0 : ovf_q ? signed_of('1, neg_q) : signed_of(q_q, neg_q);

endmodule

// ===== tb/tavs_checker.sv =====
`timescale 1ns / 1ps

module tavs_checker (
	input  logic   clk,
	input  logic   arst_n,
	tavs_cfg_if    cfg,
	tavs_item_if   item,
	tavs_result_if result,
	output int     fails,
	output int     waiting,
	output int     vertices,
	output int     beats_checked,
	output int     singular_seen
);
	import tavs_pkg::*;

	localparam longint FULL = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic signed [31:0] new_factor;
		logic [4:0]         factor_index;
		logic [62:0]        error_sum;
		logic               singular;
		logic               last;
	} factor_beat_t;

	factor_beat_t factor_q[$];

	logic [30:0]        lambda_q;
	logic               degree_scale;
	logic signed [31:0] clamp_lo;
	logic signed [31:0] clamp_hi;

	longint gram[DIM*DIM];
	longint rhs[DIM];
	longint prod[DIM];
	longint pred_acc;
	longint err_acc;
	longint edges;
	int     pos;
	bit     pos_full;

	initial begin
		fails = 0;
		vertices = 0;
		beats_checked = 0;
		singular_seen = 0;
	end

	assign waiting = factor_q.size();

	function automatic longint sat_add(longint a, longint b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > 65'sd9223372036854775807) return FULL;
		if (s < -65'sd9223372036854775807) return -FULL;
		return longint'(s[63:0]);
	endfunction

	function automatic longint sat_word(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [63:0] magnitude(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint capped(logic [63:0] m, bit neg);
		longint c;
		c = (m > 64'(FULL)) ? FULL : longint'(m);
		return neg ? -c : c;
	endfunction

	// Q32.32 product, truncated toward zero.
	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] pr;
		pr = 128'(magnitude(a)) * 128'(magnitude(b));
		if (pr[127:96] != 0) return capped('1, (a < 0) != (b < 0));
		return capped(pr[95:32], (a < 0) != (b < 0));
	endfunction

	function automatic longint fx_div(longint a, longint b, inout bit sing);
		logic [63:0]  ma, mb;
		logic [127:0] q;
		if (b == 0) begin
			sing = 1'b1;
			return 0;
		end
		ma = magnitude(a);
		mb = magnitude(b);
		if ((ma >> 32) >= mb) return capped('1, (a < 0) != (b < 0));
		q = {32'b0, ma, 32'b0} / {64'b0, mb};
		return capped(q[63:0], (a < 0) != (b < 0));
	endfunction

	task automatic clear_model();
		lambda_q = 31'd4260;
		degree_scale = 1'b0;
		clamp_lo = 32'sd0;
		clamp_hi = 32'sd327680;
		foreach (gram[i]) gram[i] = 0;
		foreach (rhs[i]) rhs[i] = 0;
		foreach (prod[i]) prod[i] = 0;
		pred_acc = 0;
		err_acc = 0;
		edges = 0;
		pos = 0;
		pos_full = 1'b0;
		factor_q.delete();
	endtask

	task automatic close_edge(longint rating, bit user);
		longint pr, e;
		logic [63:0] m;
		for (int i = 0; i < DIM; i++)
			for (int j = i; j < DIM; j++)
				gram[i*DIM+j] = sat_add(gram[i*DIM+j], prod[i] * prod[j]);
		if (user) begin
			pr = pred_acc >>> 16;
			if (pr > clamp_hi) pr = clamp_hi;
			if (pr < clamp_lo) pr = clamp_lo;
			e = rating - pr;
			m = magnitude(e);
			if (m > 64'd3037000499) err_acc = FULL;
			else err_acc = sat_add(err_acc, longint'(m * m));
		end
		if (edges < 64'hFFFF_FFFF) edges++;
		pred_acc = 0;
		pos = 0;
		pos_full = 1'b0;
		foreach (prod[i]) prod[i] = 0;
	endtask

	// Regularize, factor as L*D*L', then substitute forward, divide by D and substitute back.
	task automatic run_ldlt();
		longint lowm[DIM][DIM];
		longint diag[DIM], w[DIM], z[DIM];
		longint lam, d, s;
		bit sing;
		factor_beat_t b;
		sing = 1'b0;
		lam = longint'({lambda_q, 16'b0});
		if (degree_scale) begin
			if (edges != 0 && lam > FULL / edges) lam = FULL;
			else lam = lam * edges;
		end
		for (int i = 0; i < DIM; i++) gram[i*DIM+i] = sat_add(gram[i*DIM+i], lam);
		foreach (lowm[i, j]) lowm[i][j] = 0;
		for (int j = 0; j < DIM; j++) begin
			d = gram[j*DIM+j];
			for (int k = 0; k < j; k++) begin
				w[k] = fx_mul(lowm[j][k], diag[k]);
				d = sat_add(d, -fx_mul(lowm[j][k], w[k]));
			end
			diag[j] = d;
			for (int i = j + 1; i < DIM; i++) begin
				s = gram[j*DIM+i];
				for (int k = 0; k < j; k++) s = sat_add(s, -fx_mul(lowm[i][k], w[k]));
				lowm[i][j] = fx_div(s, d, sing);
			end
		end
		for (int i = 0; i < DIM; i++) begin
			s = rhs[i];
			for (int k = 0; k < i; k++) s = sat_add(s, -fx_mul(lowm[i][k], z[k]));
			z[i] = s;
		end
		for (int i = 0; i < DIM; i++) z[i] = fx_div(z[i], diag[i], sing);
		for (int i = DIM - 1; i >= 0; i--) begin
			s = z[i];
			for (int k = i + 1; k < DIM; k++) s = sat_add(s, -fx_mul(lowm[k][i], z[k]));
			z[i] = s;
		end
		for (int i = 0; i < DIM; i++) begin
			b.new_factor = 32'(sat_word(z[i] >>> 16));
			b.factor_index = 5'(i);
			b.error_sum = err_acc[62:0];
			b.singular = sing;
			b.last = (i == DIM - 1);
			factor_q.push_back(b);
		end
		if (sing) singular_seen++;
		vertices++;
		foreach (gram[i]) gram[i] = 0;
		foreach (rhs[i]) rhs[i] = 0;
		err_acc = 0;
		edges = 0;
	endtask

	task automatic take_element();
		longint own, nbr, tim, rat, p;
		own = item.own_factor;
		nbr = item.nbr_factor;
		tim = item.time_factor;
		rat = item.rating;
		if (!pos_full) begin
			p = sat_word((nbr * tim) >>> 16);
			prod[pos] = p;
			rhs[pos] = sat_add(rhs[pos], p * rat);
			pred_acc = sat_add(pred_acc, own * p);
			if (pos + 1 >= DIM) pos_full = 1'b1;
			else pos++;
		end
		if (item.end_of_edge || item.end_of_vertex) begin
			close_edge(rat, item.is_user);
			if (item.end_of_vertex) run_ldlt();
		end
	endtask

	task automatic report_mismatch(string msg);
		$display("%0t: factor beat %0d: %s", $time, beats_checked, msg);
		fails++;
	endtask

	task automatic check_beat();
		factor_beat_t e;
		if (factor_q.size() == 0) begin
			report_mismatch("unexpected beat");
			return;
		end
		e = factor_q.pop_front();
		if (result.new_factor !== e.new_factor)
			report_mismatch($sformatf("new_factor %h, want %h", result.new_factor,
				e.new_factor));
		if (result.factor_index !== e.factor_index)
			report_mismatch($sformatf("factor_index %0d, want %0d", result.factor_index,
				e.factor_index));
		if (result.error_sum !== e.error_sum)
			report_mismatch($sformatf("error_sum %h, want %h", result.error_sum,
				e.error_sum));
		if (result.singular !== e.singular)
			report_mismatch($sformatf("singular %b, want %b", result.singular, e.singular));
		if (result.last !== e.last)
			report_mismatch($sformatf("last %b, want %b", result.last, e.last));
		beats_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_REG_WEIGHT: lambda_q = cfg.data[30:0];
					CFG_SCALE_DEG:  degree_scale = cfg.data[0];
					CFG_MIN_RATING: clamp_lo = cfg.data;
					CFG_MAX_RATING: clamp_hi = cfg.data;
					default: ;
				endcase
			end
			if (item.valid && item.ready) take_element();
			if (result.valid && result.ready) check_beat();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import tavs_pkg::*;

	localparam logic [7:0] CFG_UNUSED = 8'd9;

	logic clk;
	logic arst_n;
	int   fails, waiting, vertices, beats_checked, singular_seen;
	int   items_sent;
	int   src_pct, snk_pct;

	tavs_cfg_if    cfg_ch();
	tavs_item_if   item_ch();
	tavs_result_if res_ch();

	tensor_als_vertex_solve i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	tavs_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_ch),
		.item          (item_ch),
		.result        (res_ch),
		.fails         (fails),
		.waiting       (waiting),
		.vertices      (vertices),
		.beats_checked (beats_checked),
		.singular_seen (singular_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("timeout with %0d factor beats outstanding", waiting);
		$display("tensor_als_vertex_solve test failed");
		$finish;
	end

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= snk_pct);
	end

	// Called and returns at a falling edge; valid drops at the falling edge before the return.
	task automatic write_reg(logic [7:0] idx, logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Called and returns at a falling edge. Valid stays high on return; the next
	// beat or settle() drives it in the same step.
	task automatic put_beat(logic [31:0] own, nbr, tim, rat, bit eoe, eov, user);
		if ($urandom_range(99) < src_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.own_factor <= own;
		item_ch.nbr_factor <= nbr;
		item_ch.time_factor <= tim;
		item_ch.rating <= rat;
		item_ch.end_of_edge <= eoe;
		item_ch.end_of_vertex <= eov;
		item_ch.is_user <= user;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [31:0] modest();
		return 32'($urandom_range(0, 262144)) - 32'd131072;
	endfunction

	// kind 0: well formed, modest values; 1: full-range noise; 2: broken framing.
	task automatic put_vertex(int nedges, bit user, int kind);
		int len;
		bit eoe, eov;
		logic [31:0] rat;
		for (int e = 0; e < nedges; e++) begin
			len = (kind == 2) ? $urandom_range(1, DIM + 3) : DIM;
			rat = (kind == 1) ? $urandom : 32'($urandom_range(0, 327680));
			for (int i = 0; i < len; i++) begin
				eov = (e == nedges - 1) && (i == len - 1);
				eoe = (i == len - 1) && !(kind == 2 && eov && $urandom_range(1));
				if (kind == 1)
					put_beat($urandom, $urandom, $urandom, rat, eoe, eov, user);
				else
					put_beat(modest(), modest(), modest(), rat, eoe, eov, user);
			end
		end
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic run_random(int count);
		int start, r;
		start = items_sent;
		while (items_sent - start < count) begin
			r = $urandom_range(99);
			put_vertex($urandom_range(1, 3), $urandom_range(1), r < 70 ? 0 : (r < 85 ? 1 : 2));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		items_sent = 0;
		src_pct = 0;
		snk_pct = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		item_ch.valid = 1'b0;
		item_ch.own_factor = '0;
		item_ch.nbr_factor = '0;
		item_ch.time_factor = '0;
		item_ch.rating = '0;
		item_ch.end_of_edge = 1'b0;
		item_ch.end_of_vertex = 1'b0;
		item_ch.is_user = 1'b0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		// Directed: field extremes, short and long edges, vertex end without edge end.
		for (int i = 0; i < DIM; i++)
			put_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				i == DIM - 1, 1'b0, 1'b1);
		for (int i = 0; i < DIM; i++)
			put_beat(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
				i == DIM - 1, i == DIM - 1, 1'b1);
		for (int i = 0; i < 3; i++)
			put_beat(modest(), modest(), modest(), 32'h0003_0000, i == 2, 1'b0, 1'b1);
		for (int i = 0; i < DIM + 2; i++)
			put_beat(modest(), modest(), modest(), 32'h0001_0000, 1'b0, i == DIM + 1, 1'b0);
		settle();

		for (int ph = 1; ph <= 6; ph++) begin
			case (ph % 4)
				0: begin src_pct = 0;  snk_pct = 0;  end
				1: begin src_pct = 85; snk_pct = 0;  end
				2: begin src_pct = 0;  snk_pct = 85; end
				default: begin src_pct = 34; snk_pct = 34; end
			endcase
			case (ph)
				1: begin
					write_reg(CFG_REG_WEIGHT, 32'd0);
					write_reg(CFG_SCALE_DEG, 32'd0);
					write_reg(CFG_MIN_RATING, 32'h8000_0000);
					write_reg(CFG_MAX_RATING, 32'h7FFF_FFFF);
					write_reg(CFG_UNUSED, $urandom);
					// An all-zero Gram matrix with no regularization hits zero pivots.
					for (int i = 0; i < DIM; i++)
						put_beat(modest(), 32'd0, modest(), 32'h0002_0000,
							i == DIM - 1, i == DIM - 1, 1'b1);
				end
				2: begin
					write_reg(CFG_REG_WEIGHT, 32'hFFFF_FFFF);
					write_reg(CFG_SCALE_DEG, 32'd1);
					write_reg(CFG_MIN_RATING, 32'd0);
					write_reg(CFG_MAX_RATING, 32'd327680);
				end
				3: begin
					write_reg(CFG_REG_WEIGHT, 32'd4260);
					write_reg(CFG_MIN_RATING, 32'd400000);
					write_reg(CFG_MAX_RATING, 32'd100000);
				end
				4: begin
					write_reg(CFG_REG_WEIGHT, $urandom_range(0, 200000));
					write_reg(CFG_SCALE_DEG, $urandom);
					write_reg(CFG_MIN_RATING, -32'($urandom_range(0, 200000)));
					write_reg(CFG_MAX_RATING, $urandom_range(0, 400000));
				end
				5: begin
					write_reg(CFG_REG_WEIGHT, 32'd1);
					write_reg(CFG_SCALE_DEG, 32'd1);
				end
				default: begin
					write_reg(CFG_REG_WEIGHT, 32'd65536);
					write_reg(CFG_SCALE_DEG, 32'd0);
					write_reg(CFG_MIN_RATING, 32'd0);
					write_reg(CFG_MAX_RATING, 32'd327680);
				end
			endcase
			run_random(60);
			settle();
		end

		$display("%0d element beats sent over %0d vertices, %0d factor beats checked",
			items_sent, vertices, beats_checked);
		$display("%0d solves hit a zero pivot; 7 register settings, 4 idling modes",
			singular_seen);
		if (fails == 0) begin
			$display("tensor_als_vertex_solve test passed");
		end else begin
			$display("tensor_als_vertex_solve test failed");
		end
		$finish;
	end

endmodule
